/* hdl/cwp_pkg.sv */
`default_nettype none

package cwp_pkg;

  // datapath widths: x/y carry 16 guard fraction bits below Q15.8
  localparam int DW        = 42;
  localparam int ZW        = 32;
  localparam int PW        = 54;
  localparam int GUARD     = 16;
  localparam int TABLE_LEN = 24;

  localparam logic signed [30:0] GAIN_Q30 = 31'sd652032875;
  localparam logic signed [23:0] W24_MAX  = 24'sh7FFFFF;
  localparam logic signed [23:0] W24_MIN  = 24'sh800000;

  typedef struct packed {
    logic signed [23:0] parent_x;
    logic signed [23:0] parent_y;
    logic        [15:0] angle;
    logic signed [23:0] offset_x;
    logic signed [23:0] offset_y;
  } cwp_in_t;

  typedef struct packed {
    logic signed [23:0] world_x;
    logic signed [23:0] world_y;
    logic        [15:0] inherited_angle;
    logic               saturated;
  } cwp_out_t;

  // fields that ride along the rotation chain untouched
  typedef struct packed {
    logic signed [23:0] parent_x;
    logic signed [23:0] parent_y;
    logic        [15:0] angle;
  } cwp_carry_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    cwp_carry_t           carry;
  } cwp_cell_t;

  // atan(2^-i) with 2^32 = full turn
  function automatic logic [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/cwp_prescale.sv */
`default_nettype none

module cwp_prescale (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cwp_pkg::cwp_in_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cwp_pkg::cwp_cell_t      out_data
);

  localparam int PW = cwp_pkg::PW;
  localparam int DW = cwp_pkg::DW;
  localparam int ZW = cwp_pkg::ZW;

  // stage a: gain multiply and quadrant fold decision
  logic                     a_valid_r;
  logic signed [PW-1:0]     prod_x_r, prod_y_r;
  logic signed [PW-1:0]     prod_x_nxt, prod_y_nxt;
  logic                     fold_r, fold_nxt;
  logic        [15:0]       zang_r, zang_nxt;
  cwp_pkg::cwp_carry_t      carry_a_r;
  logic signed [15:0]       angle_s;
  logic                     a_ready;

  // stage b: round to guard precision, apply fold
  logic                     b_valid_r;
  cwp_pkg::cwp_cell_t       b_data_r, b_data_nxt;
  logic                     b_ready;
  logic signed [PW-1:0]     rnd_x, rnd_y;
  logic signed [DW-1:0]     sx, sy;

  assign b_ready  = !b_valid_r || out_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  assign angle_s    = $signed(in_data.angle);
  assign prod_x_nxt = PW'(in_data.offset_x) * PW'(cwp_pkg::GAIN_Q30);
  assign prod_y_nxt = PW'(in_data.offset_y) * PW'(cwp_pkg::GAIN_Q30);
  assign fold_nxt   = (angle_s > 16'sh4000) || (angle_s < -16'sh4000);
  // taking away or adding half a turn is a flip of the top bit
  assign zang_nxt   = fold_nxt ? (in_data.angle ^ 16'h8000) : in_data.angle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      prod_x_r           <= prod_x_nxt;
      prod_y_r           <= prod_y_nxt;
      fold_r             <= fold_nxt;
      zang_r             <= zang_nxt;
      carry_a_r.parent_x <= in_data.parent_x;
      carry_a_r.parent_y <= in_data.parent_y;
      carry_a_r.angle    <= in_data.angle;
    end
  end

  assign rnd_x = (prod_x_r + PW'(2**13)) >>> 14;
  assign rnd_y = (prod_y_r + PW'(2**13)) >>> 14;
  assign sx    = DW'(rnd_x);
  assign sy    = DW'(rnd_y);

  always_comb begin
    b_data_nxt.x     = fold_r ? -sx : sx;
    b_data_nxt.y     = fold_r ? -sy : sy;
    b_data_nxt.z     = {zang_r, {(ZW - 16){1'b0}}};
    b_data_nxt.carry = carry_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r && b_ready) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_data  = b_data_r;

endmodule

`default_nettype wire

/* hdl/cwp_cell.sv */
`default_nettype none

module cwp_cell #(
  parameter int STAGE = 0
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cwp_pkg::cwp_cell_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cwp_pkg::cwp_cell_t       out_data
);

  localparam int DW = cwp_pkg::DW;
  localparam int ZW = cwp_pkg::ZW;
  localparam logic signed [ZW-1:0] ATAN = $signed(cwp_pkg::atan_entry(5'(STAGE)));

  logic                  valid_r;
  cwp_pkg::cwp_cell_t    data_r, data_nxt;
  logic signed [DW-1:0]  dx, dy;
  logic                  pos;

  assign in_ready = !valid_r || out_ready;

  assign dx  = in_data.y >>> STAGE;
  assign dy  = in_data.x >>> STAGE;
  assign pos = !in_data.z[ZW-1];

  always_comb begin
    data_nxt.carry = in_data.carry;
    if (pos) begin
      data_nxt.x = in_data.x - dx;
      data_nxt.y = in_data.y + dy;
      data_nxt.z = in_data.z - ATAN;
    end else begin
      data_nxt.x = in_data.x + dx;
      data_nxt.y = in_data.y - dy;
      data_nxt.z = in_data.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

/* hdl/cwp_finish.sv */
`default_nettype none

module cwp_finish (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cwp_pkg::cwp_cell_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cwp_pkg::cwp_out_t        out_data
);

  localparam int DW    = cwp_pkg::DW;
  localparam int GUARD = cwp_pkg::GUARD;
  localparam int RW    = DW - GUARD;

  logic                  valid_r;
  cwp_pkg::cwp_out_t     data_r, data_nxt;
  logic signed [DW-1:0]  xr, yr;
  logic signed [RW-1:0]  rx, ry;
  logic signed [RW:0]    sum_x, sum_y;
  logic                  hi_x, lo_x, hi_y, lo_y;

  assign in_ready = !valid_r || out_ready;

  // round half up back to Q15.8
  assign xr = (in_data.x + DW'(2**(GUARD - 1))) >>> GUARD;
  assign yr = (in_data.y + DW'(2**(GUARD - 1))) >>> GUARD;
  assign rx = RW'(xr);
  assign ry = RW'(yr);

  assign sum_x = (RW + 1)'(in_data.carry.parent_x) + (RW + 1)'(rx);
  assign sum_y = (RW + 1)'(in_data.carry.parent_y) + (RW + 1)'(ry);

  assign hi_x = sum_x > (RW + 1)'(cwp_pkg::W24_MAX);
  assign lo_x = sum_x < (RW + 1)'(cwp_pkg::W24_MIN);
  assign hi_y = sum_y > (RW + 1)'(cwp_pkg::W24_MAX);
  assign lo_y = sum_y < (RW + 1)'(cwp_pkg::W24_MIN);

  always_comb begin
    if (hi_x) begin
      data_nxt.world_x = cwp_pkg::W24_MAX;
    end else if (lo_x) begin
      data_nxt.world_x = cwp_pkg::W24_MIN;
    end else begin
      data_nxt.world_x = 24'(sum_x);
    end
    if (hi_y) begin
      data_nxt.world_y = cwp_pkg::W24_MAX;
    end else if (lo_y) begin
      data_nxt.world_y = cwp_pkg::W24_MIN;
    end else begin
      data_nxt.world_y = 24'(sum_y);
    end
    data_nxt.inherited_angle = in_data.carry.angle;
    data_nxt.saturated       = hi_x || lo_x || hi_y || lo_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

/* hdl/child_world_position_rotate_translate.sv */
// channel | ports                         | moves
// --------+-------------------------------+------------------------------------
// input   | in_valid, in_ready, in_data   | parent pose and child offset request
// output  | out_valid, out_ready, out_data| child world position and angle
//
// one request per cycle unless the output stalls; a request passes two
// prescale registers, one register per rotation cell, one output register
// throughput is set by the cell chain: every cell is a register stage
// each stage holds its item only while the next one is full and stalled,
// so empty slots in the chain keep accepting requests while a result waits
// synchronous active-low reset clears the valid bits only

`default_nettype none

module child_world_position_rotate_translate #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cwp_pkg::cwp_in_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cwp_pkg::cwp_out_t       out_data
);

  localparam int NCELLS = (CORDIC_STAGES < cwp_pkg::TABLE_LEN) ?
                          CORDIC_STAGES : cwp_pkg::TABLE_LEN;

  logic                chain_valid [NCELLS+1];
  logic                chain_ready [NCELLS+1];
  cwp_pkg::cwp_cell_t  chain_data  [NCELLS+1];

  cwp_prescale u_prescale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    cwp_cell #(
      .STAGE (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_data   (chain_data[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_data  (chain_data[k+1])
    );
  end

  cwp_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[NCELLS]),
    .in_ready  (chain_ready[NCELLS]),
    .in_data   (chain_data[NCELLS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* hdl/cwp_checker.sv */
`default_nettype none

module cwp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire cwp_pkg::cwp_in_t   in_data,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire cwp_pkg::cwp_out_t  out_data
);

  // a waiting request keeps its payload until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed while waiting");

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

  // an empty output register means nothing in the chain blocks a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

  a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.world_x == cwp_pkg::W24_MAX) || (out_data.world_x == cwp_pkg::W24_MIN) ||
      (out_data.world_y == cwp_pkg::W24_MAX) || (out_data.world_y == cwp_pkg::W24_MIN))
    else $error("saturated flag without a clamped coordinate");

endmodule

bind child_world_position_rotate_translate cwp_checker u_cwp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
